@@ src/rowf_pkg.sv @@
// ----------------------------------------------------------------------------
// Rank-order window filter package
// Shared types, register codes and fixed field widths for the filter core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rowf_pkg;

    // Fixed field widths.
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int OUT_COL_W  = 10;
    localparam int MODE_W     = 2;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Largest image height in rows.
    localparam int MAX_HEIGHT = 4096;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Register reset values.
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;

    // Input opcode for a pixel transaction; anything else only drains results.
    localparam logic OP_PIXEL = 1'b0;

    // Filter selection.
    typedef enum logic [MODE_W-1:0] {
        MODE_MEDIAN = 2'd0,
        MODE_MIN    = 2'd1,
        MODE_MAX    = 2'd2,
        MODE_COPY   = 2'd3
    } mode_t;

    // Control word that travels alongside the window through the sorter.
    typedef struct packed {
        logic                  valid;
        logic                  keep;
        logic [PIX_W-1:0]      pass_pix;
        logic [ROW_W-1:0]      row;
        logic [OUT_COL_W-1:0]  col;
        logic                  frame_end;
    } rowf_ctrl_t;

endpackage

@@ src/rowf_line_bank.sv @@
// ----------------------------------------------------------------------------
// Line store bank
// One image row of pixels with one write port and two registered read ports.
// A read of the address written in the same cycle returns the new pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rowf_line_bank #(
    parameter int DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [rowf_pkg::PIX_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
    output logic [rowf_pkg::PIX_W-1:0] rd_data_a,
    output logic [rowf_pkg::PIX_W-1:0] rd_data_b
);
    import rowf_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_a_reg;
    logic [PIX_W-1:0] rd_b_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read ports with write-through on an address match.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
            rd_b_reg <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

@@ src/rowf_cx_cell.sv @@
// ----------------------------------------------------------------------------
// Compare-exchange cell
// Registers the smaller of two pixels on one output and the larger on the other.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rowf_cx_cell (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rowf_pkg::PIX_W-1:0] a,
    input  logic [rowf_pkg::PIX_W-1:0] b,
    output logic [rowf_pkg::PIX_W-1:0] lo,
    output logic [rowf_pkg::PIX_W-1:0] hi
);
    import rowf_pkg::*;

    logic [PIX_W-1:0] lo_reg;
    logic [PIX_W-1:0] hi_reg;
    logic             swap;

    assign swap = (a > b);

    // Ordered pair, held while the pipeline is frozen.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= swap ? b : a;
            hi_reg <= swap ? a : b;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

@@ src/rowf_sort_stage.sv @@
// ----------------------------------------------------------------------------
// Sorter stage
// One step of an odd-even transposition sort: a row of compare-exchange cells
// on the even or odd pairs, unpaired pixels registered as they are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rowf_sort_stage #(
    parameter int N     = 9,
    parameter int PHASE = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic [N-1:0][rowf_pkg::PIX_W-1:0]  data_in,
    input  rowf_pkg::rowf_ctrl_t               ctrl_in,
    output logic [N-1:0][rowf_pkg::PIX_W-1:0]  data_out,
    output rowf_pkg::rowf_ctrl_t               ctrl_out
);
    import rowf_pkg::*;

    logic [PIX_W-1:0] res [N];
    rowf_ctrl_t       ctrl_reg;

    genvar gi;

    // Cells on the pairs of this phase, plain registers elsewhere.
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_lane
            if (((gi % 2) == PHASE) && (gi + 1 < N))
            begin : g_pair
                rowf_cx_cell u_cell (
                    .clk (clk),
                    .en  (en),
                    .a   (data_in[gi]),
                    .b   (data_in[gi+1]),
                    .lo  (res[gi]),
                    .hi  (res[gi+1])
                );
            end
            else if (!((gi >= 1) && (((gi - 1) % 2) == PHASE)))
            begin : g_single
                logic [PIX_W-1:0] hold_reg;

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        hold_reg <= data_in[gi];
                    end
                end

                assign res[gi] = hold_reg;
            end
            assign data_out[gi] = res[gi];
        end
    endgenerate

    // Control word follows the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    assign ctrl_out = ctrl_reg;

endmodule

@@ src/rank_order_window_filter_core.sv @@
// ----------------------------------------------------------------------------
// Rank-order window filter core
// Median, minimum or maximum over a square window of a raster pixel stream
// (or a plain copy), with border pixels passed through and line stores for the window rows.
// ----------------------------------------------------------------------------
// Pipeline: a released result is read from the line store, shifted into the
// window, passed through the sorter stages one after another and then held
// in the output register, each step moving only while the pipeline advances.
// Throughput: one transaction per cycle in and one result per cycle out; the
// whole pipeline holds only while a result waits on out_stall.
// Reset: counters clear, registers take their defaults, the line store is
// left unwritten (no clearing pass); a register write restarts the frame.
`timescale 1ns / 1ps

module rank_order_window_filter_core #(
    parameter int KERNEL_SIZE = 3,
    parameter int MAX_WIDTH   = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_write,
    input  logic [rowf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rowf_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input channel.
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             opcode,
    input  logic [rowf_pkg::PIX_W-1:0]       pixel_in,
    // Output channel.
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rowf_pkg::PIX_W-1:0]       pixel_out,
    output logic [rowf_pkg::ROW_W-1:0]       out_row,
    output logic [rowf_pkg::OUT_COL_W-1:0]   out_col,
    output logic                             frame_end
);
    import rowf_pkg::*;

    localparam int RADIUS   = KERNEL_SIZE / 2;
    localparam int WIN      = 2 * RADIUS + 1;
    localparam int WIN_AREA = WIN * WIN;
    localparam int MID      = WIN_AREA / 2;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int W_W      = $clog2(MAX_WIDTH + 1);
    localparam int WX_W     = W_W + 1;
    localparam int BANK_W   = $clog2(WIN);
    localparam int D_W      = $clog2(RADIUS * MAX_WIDTH + RADIUS + 2);

    // Configuration registers.
    mode_t                mode_reg;
    logic [WIDTH_W-1:0]   width_reg;
    logic [HEIGHT_W-1:0]  height_reg;
    logic                 cfg_hit;

    // Frame counters.
    logic [HEIGHT_W-1:0]  in_row_reg,   in_row_next;
    logic [COL_W-1:0]     in_col_reg,   in_col_next;
    logic [BANK_W-1:0]    in_bank_reg,  in_bank_next;
    logic [ROW_W-1:0]     out_row_reg,  out_row_next;
    logic [COL_W-1:0]     out_col_reg,  out_col_next;
    logic [BANK_W-1:0]    out_bank_reg, out_bank_next;
    logic [COL_W-1:0]     fc_reg,       fc_next;
    logic                 start_reg,    start_next;
    logic [D_W-1:0]       d_reg,        d_next;

    // Derived control.
    logic [W_W-1:0]       eff_w;
    logic [HEIGHT_W-1:0]  eff_h;
    logic [D_W-1:0]       lag_p1;
    logic [D_W-1:0]       d_st;
    logic [COL_W-1:0]     fc_init;
    logic [COL_W-1:0]     fc_cur;
    logic                 adv;
    logic                 acc;
    logic                 st;
    logic                 in_col_last;
    logic                 in_done;
    logic                 in_done_after;
    logic                 fire;
    logic                 out_last;
    logic                 border;
    logic [COL_W+OUT_COL_W-1:0] col_ext;

    // Pipeline.
    rowf_ctrl_t                      s1_ctrl_reg, s1_ctrl_next;
    logic [BANK_W-1:0]               s1_bank_reg;
    rowf_ctrl_t                      s2_ctrl_reg, s2_ctrl_next;
    logic [WIN_AREA-1:0][PIX_W-1:0]  win_reg;
    logic [PIX_W-1:0]                col_data  [WIN];
    logic [PIX_W-1:0]                pass_data [WIN];
    logic [WIN_AREA-1:0][PIX_W-1:0]  st_data [WIN_AREA+1];
    rowf_ctrl_t                      st_ctrl [WIN_AREA+1];
    rowf_ctrl_t                      fin_ctrl;
    logic [PIX_W-1:0]                result;
    logic                            out_valid_reg;
    logic [PIX_W-1:0]                pixel_out_reg;
    logic [ROW_W-1:0]                out_row_reg_q;
    logic [OUT_COL_W-1:0]            out_col_reg_q;
    logic                            frame_end_reg;

    // Handshake: the pipeline moves unless a finished result is held.
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;
    assign acc      = in_valid && adv;

    // Configuration write decode; any known index restarts the frame.
    assign cfg_hit = cfg_write &&
                     ((cfg_index == CFG_MODE) || (cfg_index == CFG_WIDTH) ||
                      (cfg_index == CFG_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_MEDIAN;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= mode_t'(cfg_data[MODE_W-1:0]);
                CFG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    // Image size in use, clamped to the supported range.
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = W_W'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            eff_w = W_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = W_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            eff_h = HEIGHT_W'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            eff_h = HEIGHT_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    // Input must lead output by radius rows plus radius pixels, plus one.
    assign lag_p1 = D_W'(RADIUS) * D_W'(eff_w) + D_W'(RADIUS + 1);

    // First fetch column of a frame: the radius folded into the row width.
    always_comb
    begin
        logic [W_W-1:0] v;
        v = W_W'(RADIUS);
        for (int k = 0; k < RADIUS; k++)
        begin
            if (v >= eff_w)
            begin
                v = v - eff_w;
            end
        end
        fc_init = COL_W'(v);
    end

    assign fc_cur = start_reg ? fc_init : fc_reg;

    // Item decisions.
    assign in_done       = (in_row_reg == eff_h);
    assign in_col_last   = (W_W'(in_col_reg) == eff_w - W_W'(1));
    assign st            = acc && (opcode == OP_PIXEL) && !in_done;
    assign in_done_after = in_done ||
                           (st && in_col_last && (in_row_reg + HEIGHT_W'(1) == eff_h));
    assign d_st          = d_reg + D_W'(st);
    assign fire          = acc && ((d_st >= lag_p1) || in_done_after);
    assign out_last      = (HEIGHT_W'(out_row_reg) == eff_h - HEIGHT_W'(1)) &&
                           (W_W'(out_col_reg) == eff_w - W_W'(1));
    assign border        = !((out_row_reg >= ROW_W'(RADIUS)) &&
                             (HEIGHT_W'(out_row_reg) + HEIGHT_W'(RADIUS) < eff_h) &&
                             (W_W'(out_col_reg) >= W_W'(RADIUS)) &&
                             (WX_W'(out_col_reg) + WX_W'(RADIUS) < WX_W'(eff_w)));
    assign col_ext       = {{OUT_COL_W{1'b0}}, out_col_reg};

    // Counter next state.
    always_comb
    begin
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_bank_next  = in_bank_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_bank_next = out_bank_reg;
        fc_next       = fc_reg;
        start_next    = start_reg;
        d_next        = d_st - D_W'(fire);

        // A stored pixel advances the input position.
        if (st)
        begin
            if (in_col_last)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + HEIGHT_W'(1);
                in_bank_next = (in_bank_reg == BANK_W'(WIN - 1)) ?
                               '0 : in_bank_reg + BANK_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end

        // A released result advances the output and fetch positions.
        if (fire)
        begin
            start_next = 1'b0;
            fc_next    = (W_W'(fc_cur) == eff_w - W_W'(1)) ? '0 : fc_cur + COL_W'(1);
            if (W_W'(out_col_reg) == eff_w - W_W'(1))
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + ROW_W'(1);
                out_bank_next = (out_bank_reg == BANK_W'(WIN - 1)) ?
                                '0 : out_bank_reg + BANK_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end

        // End of frame or a register write starts a new frame.
        if ((fire && out_last) || cfg_hit)
        begin
            in_row_next   = '0;
            in_col_next   = '0;
            in_bank_next  = '0;
            out_row_next  = '0;
            out_col_next  = '0;
            out_bank_next = '0;
            fc_next       = '0;
            start_next    = 1'b1;
            d_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_bank_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_bank_reg <= '0;
            fc_reg       <= '0;
            start_reg    <= 1'b1;
            d_reg        <= '0;
        end
        else
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_bank_reg  <= in_bank_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_bank_reg <= out_bank_next;
            fc_reg       <= fc_next;
            start_reg    <= start_next;
            d_reg        <= d_next;
        end
    end

    // Line store: one bank per window row, rows taken in turn.
    genvar gb;
    generate
        for (gb = 0; gb < WIN; gb++)
        begin : g_bank
            rowf_line_bank #(
                .DEPTH (MAX_WIDTH)
            ) u_bank (
                .clk       (clk),
                .wr_en     (st && (in_bank_reg == BANK_W'(gb))),
                .wr_addr   (in_col_reg),
                .wr_data   (pixel_in),
                .rd_en     (adv),
                .rd_addr_a (fc_cur),
                .rd_addr_b (out_col_reg),
                .rd_data_a (col_data[gb]),
                .rd_data_b (pass_data[gb])
            );
        end
    endgenerate

    // Control for the result released by this transaction.
    always_comb
    begin
        s1_ctrl_next           = '0;
        s1_ctrl_next.valid     = fire;
        s1_ctrl_next.keep      = (mode_reg == MODE_COPY) || border;
        s1_ctrl_next.row       = out_row_reg;
        s1_ctrl_next.col       = col_ext[OUT_COL_W-1:0];
        s1_ctrl_next.frame_end = out_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s2_ctrl_reg <= s2_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_bank_reg <= out_bank_reg;
        end
    end

    // Pass-through pixel comes from the bank of the result's own row.
    always_comb
    begin
        s2_ctrl_next          = s1_ctrl_reg;
        s2_ctrl_next.pass_pix = pass_data[s1_bank_reg];
    end

    // Window: a row of column registers, the fetched column shifts in.
    always_ff @(posedge clk)
    begin
        if (adv && s1_ctrl_reg.valid)
        begin
            for (int i = 0; i < WIN_AREA - WIN; i++)
            begin
                win_reg[i] <= win_reg[i + WIN];
            end
            for (int i = 0; i < WIN; i++)
            begin
                win_reg[WIN_AREA - WIN + i] <= col_data[i];
            end
        end
    end

    // Sorter: odd-even transposition, one stage per window pixel.
    assign st_data[0] = win_reg;
    assign st_ctrl[0] = s2_ctrl_reg;

    genvar gs;
    generate
        for (gs = 0; gs < WIN_AREA; gs++)
        begin : g_stage
            rowf_sort_stage #(
                .N     (WIN_AREA),
                .PHASE (gs % 2)
            ) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (adv),
                .data_in  (st_data[gs]),
                .ctrl_in  (st_ctrl[gs]),
                .data_out (st_data[gs+1]),
                .ctrl_out (st_ctrl[gs+1])
            );
        end
    endgenerate

    assign fin_ctrl = st_ctrl[WIN_AREA];

    // Pick the rank that the mode asks for, or the pass-through pixel.
    always_comb
    begin
        if (fin_ctrl.keep)
        begin
            result = fin_ctrl.pass_pix;
        end
        else
        begin
            case (mode_reg)
                MODE_MIN: result = st_data[WIN_AREA][0];
                MODE_MAX: result = st_data[WIN_AREA][WIN_AREA-1];
                default:  result = st_data[WIN_AREA][MID];
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= fin_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pixel_out_reg <= result;
            out_row_reg_q <= fin_ctrl.row;
            out_col_reg_q <= fin_ctrl.col;
            frame_end_reg <= fin_ctrl.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign out_row   = out_row_reg_q;
    assign out_col   = out_col_reg_q;
    assign frame_end = frame_end_reg;

    // The input never runs further ahead of the output than the window lag.
    a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
        d_reg <= lag_p1)
        else $error("input lead exceeds the window lag");

    // The input row count never passes the image height.
    a_in_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= eff_h)
        else $error("input row count past image height");

    // The last result of a frame clears the output position, the input row and the lead and sets the start flag.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && out_last) |=> (out_row_reg == '0) && (out_col_reg == '0) &&
                               (in_row_reg == '0) && (d_reg == '0) && start_reg)
        else $error("counters not cleared after the end of frame");

    // The sorter delivers its first, middle and last pixels in order.
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        fin_ctrl.valid |-> (st_data[WIN_AREA][0] <= st_data[WIN_AREA][MID]) &&
                           (st_data[WIN_AREA][MID] <= st_data[WIN_AREA][WIN_AREA-1]))
        else $error("sorter output out of order");

endmodule
